// File: hw/rtl/pcrc_pkg.sv
`default_nettype none

package pcrc_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 25;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 25;
    localparam int unsigned CFG_IDX_W = 1;

    // default sizes
    localparam int unsigned PAGE_BYTES_DEF        = 4096;
    localparam int unsigned MAX_REQUEST_BYTES_DEF = 16777216;

    // wire framing
    localparam logic [ADDR_W-1:0] SLOT_BYTES = ADDR_W'(4);

    // crc32c, reflected
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_IN_PAGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LENGTH = 1'b1;

    // register reset values
    localparam logic [START_W-1:0] START_RESET  = '0;
    localparam logic [LEN_W-1:0]   LENGTH_RESET = LEN_W'(1);

    typedef struct packed {
        logic               restart;
        logic [START_W-1:0] start_mod;
        logic [LEN_W-1:0]   sat_len;
    } restart_t;

    typedef struct packed {
        logic [ADDR_W-1:0] wire_address;
        logic [BYTE_W-1:0] byte_out;
        logic              crc_valid;
        logic [CRC_W-1:0]  crc_value;
        logic [ADDR_W-1:0] crc_address;
        logic              request_done;
        logic [ADDR_W-1:0] encoded_size;
        logic [LEN_W-1:0]  bytes_consumed;
    } result_t;

    // one byte through the crc32c register, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // start offset reduced modulo the page size by restoring subtraction
    function automatic logic [START_W-1:0] page_mod(logic [START_W-1:0] start,
                                                     int unsigned page);
        logic [23:0] r;
        logic [23:0] d;
        r = 24'(start);
        for (int i = 7; i >= 0; i--)
        begin
            d = 24'(page << i);
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[START_W-1:0];
    endfunction

    // request length clipped to the largest request
    function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] len, int unsigned max_bytes);
        logic [30:0] m;
        m = 31'(max_bytes);
        if (31'(len) > m)
        begin
            return m[LEN_W-1:0];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pcrc_data_if.sv
`default_nettype none

interface pcrc_data_if;
    logic                         valid;
    logic                         ready;
    logic [pcrc_pkg::BYTE_W-1:0]  data_byte;
    logic                         end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcrc_result_if.sv
`default_nettype none

interface pcrc_result_if;
    logic                         valid;
    logic                         ready;
    logic [pcrc_pkg::ADDR_W-1:0]  wire_address;
    logic [pcrc_pkg::BYTE_W-1:0]  byte_out;
    logic                         crc_valid;
    logic [pcrc_pkg::CRC_W-1:0]   crc_value;
    logic [pcrc_pkg::ADDR_W-1:0]  crc_address;
    logic                         request_done;
    logic [pcrc_pkg::ADDR_W-1:0]  encoded_size;
    logic [pcrc_pkg::LEN_W-1:0]   bytes_consumed;

    modport source (output valid, output wire_address, output byte_out, output crc_valid,
                    output crc_value, output crc_address, output request_done,
                    output encoded_size, output bytes_consumed, input ready);
    modport sink   (input valid, input wire_address, input byte_out, input crc_valid,
                    input crc_value, input crc_address, input request_done,
                    input encoded_size, input bytes_consumed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcrc_cfg_if.sv
`default_nettype none

interface pcrc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pcrc_pkg::CFG_IDX_W-1:0] index;
    logic [pcrc_pkg::LEN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcrc_cfg.sv
`default_nettype none

module pcrc_cfg #(
    parameter int unsigned PAGE_BYTES        = pcrc_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_REQUEST_BYTES = pcrc_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [pcrc_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [pcrc_pkg::LEN_W-1:0]     wr_data,
    output pcrc_pkg::restart_t                  restart
);

    logic [pcrc_pkg::START_W-1:0] start_mod_reg;
    logic [pcrc_pkg::START_W-1:0] start_mod_next;
    logic [pcrc_pkg::LEN_W-1:0]   sat_len_reg;
    logic [pcrc_pkg::LEN_W-1:0]   sat_len_next;

    always_comb
    begin
        start_mod_next = start_mod_reg;
        sat_len_next   = sat_len_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                pcrc_pkg::REG_START_IN_PAGE:
                begin
                    start_mod_next = pcrc_pkg::page_mod(wr_data[pcrc_pkg::START_W-1:0],
                                                        PAGE_BYTES);
                end
                pcrc_pkg::REG_REQUEST_LENGTH:
                begin
                    sat_len_next = pcrc_pkg::sat_len(wr_data, MAX_REQUEST_BYTES);
                end
                default:
                begin
                    start_mod_next = start_mod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mod_reg <= pcrc_pkg::page_mod(pcrc_pkg::START_RESET, PAGE_BYTES);
            sat_len_reg   <= pcrc_pkg::sat_len(pcrc_pkg::LENGTH_RESET, MAX_REQUEST_BYTES);
        end
        else
        begin
            start_mod_reg <= start_mod_next;
            sat_len_reg   <= sat_len_next;
        end
    end

    // the core reloads from the values being written in the same edge
    assign restart.restart   = wr_en;
    assign restart.start_mod = start_mod_next;
    assign restart.sat_len   = sat_len_next;

endmodule

`default_nettype wire

// File: hw/rtl/pcrc_core.sv
`default_nettype none

module pcrc_core #(
    parameter int unsigned PAGE_BYTES        = pcrc_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_REQUEST_BYTES = pcrc_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [pcrc_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        end_of_data,
    input  wire pcrc_pkg::restart_t          restart,
    output pcrc_pkg::result_t                result
);

    localparam int unsigned PW = $clog2(PAGE_BYTES + 1);
    localparam logic [PW-1:0] PAGE_END = PW'(PAGE_BYTES);
    localparam logic [pcrc_pkg::LEN_W-1:0] LEN_RESET =
        pcrc_pkg::sat_len(pcrc_pkg::LENGTH_RESET, MAX_REQUEST_BYTES);
    localparam logic [PW-1:0] POS_RESET =
        PW'(pcrc_pkg::page_mod(pcrc_pkg::START_RESET, PAGE_BYTES));

    logic [pcrc_pkg::CRC_W-1:0]  crc_reg,      crc_next;
    logic [PW-1:0]               pos_reg,      pos_next;
    logic [pcrc_pkg::LEN_W-1:0]  remain_reg,   remain_next;
    logic [pcrc_pkg::ADDR_W-1:0] wptr_reg,     wptr_next;
    logic [pcrc_pkg::ADDR_W-1:0] slot_reg,     slot_next;
    logic                        finished_reg, finished_next;
    logic [pcrc_pkg::LEN_W-1:0]  consumed_reg, consumed_next;

    logic [pcrc_pkg::CRC_W-1:0]  crc_upd;
    logic [PW-1:0]               pos_inc;
    logic [pcrc_pkg::LEN_W-1:0]  remain_dec;
    logic [pcrc_pkg::ADDR_W-1:0] wptr_inc;
    logic                        last_byte;
    logic                        close;

    assign crc_upd    = pcrc_pkg::crc_byte(crc_reg, data_byte);
    assign pos_inc    = pos_reg + PW'(1);
    assign remain_dec = remain_reg - pcrc_pkg::LEN_W'(1);
    assign wptr_inc   = wptr_reg + pcrc_pkg::ADDR_W'(1);
    assign last_byte  = end_of_data || (remain_dec == '0);
    assign close      = last_byte || (pos_inc >= PAGE_END);

    always_comb
    begin
        result        = '0;
        crc_next      = crc_reg;
        pos_next      = pos_reg;
        remain_next   = remain_reg;
        wptr_next     = wptr_reg;
        slot_next     = slot_reg;
        finished_next = finished_reg;
        consumed_next = consumed_reg;

        if (finished_reg)
        begin
            // request over: item swallowed, totals repeated
            result.request_done   = 1'b1;
            result.encoded_size   = slot_reg;
            result.bytes_consumed = consumed_reg;
        end
        else
        begin
            result.wire_address   = wptr_reg;
            result.byte_out       = data_byte;
            result.encoded_size   = wptr_inc;
            result.bytes_consumed = consumed_reg + pcrc_pkg::LEN_W'(1);
            result.crc_valid      = close;
            result.request_done   = last_byte;
            if (close)
            begin
                result.crc_value   = ~crc_upd;
                result.crc_address = slot_reg;
            end

            if (accept)
            begin
                remain_next   = remain_dec;
                consumed_next = consumed_reg + pcrc_pkg::LEN_W'(1);
                if (close)
                begin
                    crc_next      = pcrc_pkg::CRC_INIT;
                    pos_next      = '0;
                    slot_next     = wptr_inc;
                    wptr_next     = wptr_inc + pcrc_pkg::SLOT_BYTES;
                    finished_next = last_byte;
                end
                else
                begin
                    crc_next  = crc_upd;
                    pos_next  = pos_inc;
                    wptr_next = wptr_inc;
                end
            end
        end

        if (restart.restart)
        begin
            crc_next      = pcrc_pkg::CRC_INIT;
            pos_next      = PW'(restart.start_mod);
            remain_next   = restart.sat_len;
            wptr_next     = pcrc_pkg::SLOT_BYTES;
            slot_next     = '0;
            finished_next = (restart.sat_len == '0);
            consumed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= pcrc_pkg::CRC_INIT;
            pos_reg      <= POS_RESET;
            remain_reg   <= LEN_RESET;
            wptr_reg     <= pcrc_pkg::SLOT_BYTES;
            slot_reg     <= '0;
            finished_reg <= (LEN_RESET == '0);
            consumed_reg <= '0;
        end
        else
        begin
            crc_reg      <= crc_next;
            pos_reg      <= pos_next;
            remain_reg   <= remain_next;
            wptr_reg     <= wptr_next;
            slot_reg     <= slot_next;
            finished_reg <= finished_next;
            consumed_reg <= consumed_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pcrc_obuf.sv
`default_nettype none

module pcrc_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pcrc_pkg::result_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pcrc_pkg::result_t      out_item
);

    logic              valid_reg;
    logic              valid_next;
    pcrc_pkg::result_t item_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/page_crc32c_interleave_encoder.sv
// Per-page CRC32c framing encoder: file bytes come in one item at a time on
// data, and every item gives exactly one result item on result in the cycle after
// it is accepted. Bytes are cut into fragments ending on page boundaries (the
// first is short when start_in_page is not zero, the last when the request
// length or end_of_data ends it); each fragment sits behind a 4-byte CRC slot
// in the wire buffer. A result carries the byte's wire address and, on a
// closing byte, the fragment's CRC32c and slot address. Throughput is one item
// per clock: the byte-wide CRC update and the pointer arithmetic are a single
// combinational pass between the state registers and the output register, and
// data.ready drops only while the output register holds an item that the sink
// does not take. Items after the request completes are swallowed and answered
// with the totals. Writing either register on cfg (always ready) restarts the
// request; write only while no result is outstanding.
`default_nettype none

module page_crc32c_interleave_encoder #(
    parameter int unsigned PAGE_BYTES        = pcrc_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_REQUEST_BYTES = pcrc_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pcrc_data_if.sink     data,
    pcrc_result_if.source result,
    pcrc_cfg_if.sink      cfg
);

    pcrc_pkg::restart_t restart;
    pcrc_pkg::result_t  core_item;
    pcrc_pkg::result_t  out_item;
    logic               accept;

    // register writes never stall
    assign cfg.ready = 1'b1;
    assign accept    = data.valid && data.ready;

    // register file, start offset folded into the page here
    pcrc_cfg #(
        .PAGE_BYTES        (PAGE_BYTES),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .restart  (restart)
    );

    // crc, page position and wire pointers
    pcrc_core #(
        .PAGE_BYTES        (PAGE_BYTES),
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data.data_byte),
        .end_of_data (data.end_of_data),
        .restart     (restart),
        .result      (core_item)
    );

    // output register, frees the input side as soon as the sink takes the item
    pcrc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (data.valid),
        .in_ready  (data.ready),
        .in_item   (core_item),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_item  (out_item)
    );

    assign result.wire_address   = out_item.wire_address;
    assign result.byte_out       = out_item.byte_out;
    assign result.crc_valid      = out_item.crc_valid;
    assign result.crc_value      = out_item.crc_value;
    assign result.crc_address    = out_item.crc_address;
    assign result.request_done   = out_item.request_done;
    assign result.encoded_size   = out_item.encoded_size;
    assign result.bytes_consumed = out_item.bytes_consumed;

endmodule

`default_nettype wire

// File: hw/rtl/pcrc_checker.sv
`default_nettype none

module pcrc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          data_valid,
    input wire logic                          data_ready,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [pcrc_pkg::ADDR_W-1:0]   wire_address,
    input wire logic                          crc_valid,
    input wire logic [pcrc_pkg::CRC_W-1:0]    crc_value,
    input wire logic [pcrc_pkg::ADDR_W-1:0]   crc_address,
    input wire logic                          request_done,
    input wire logic [pcrc_pkg::ADDR_W-1:0]   encoded_size,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    logic done_seen_reg;
    logic done_seen_next;
    logic res_take;

    assign res_take = res_valid && res_ready;

    always_comb
    begin
        done_seen_next = done_seen_reg;
        if (res_take && request_done)
        begin
            done_seen_next = 1'b1;
        end
        if (cfg_valid && cfg_ready)
        begin
            done_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_seen_reg <= 1'b0;
        end
        else
        begin
            done_seen_reg <= done_seen_next;
        end
    end

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(wire_address))
        else $error("result dropped or changed while stalled");

    // every accepted byte shows up on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready |=> res_valid)
        else $error("accepted item gave no result");

    // closing byte sits right before the encoded end, after its slot
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && crc_valid |->
            encoded_size == wire_address + pcrc_pkg::ADDR_W'(1) &&
            crc_address < wire_address)
        else $error("closing byte does not match framing totals");

    // no crc fields without a close
    a_no_crc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !crc_valid |-> crc_value == '0 && crc_address == '0)
        else $error("crc fields set on a non-closing byte");

    // after completion only empty results until a restart
    a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && done_seen_reg |-> request_done && !crc_valid && wire_address == '0)
        else $error("data result after request completed");

endmodule

bind page_crc32c_interleave_encoder pcrc_checker u_pcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_valid   (data.valid),
    .data_ready   (data.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .wire_address (result.wire_address),
    .crc_valid    (result.crc_valid),
    .crc_value    (result.crc_value),
    .crc_address  (result.crc_address),
    .request_done (result.request_done),
    .encoded_size (result.encoded_size),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

`default_nettype wire

// File: sim/page_crc32c_interleave_encoder_tb.sv
`default_nettype none

module page_crc32c_interleave_encoder_tb;

    import pcrc_pkg::*;

    // page and request size the block is built with
    localparam int unsigned PAGE    = PAGE_BYTES_DEF;
    localparam int unsigned MAX_REQ = MAX_REQUEST_BYTES_DEF;

    // random items that do real work before the stimulus stops
    localparam int unsigned RANDOM_BYTES = 1300;

    // generous bound on the whole run, in clock cycles
    localparam int unsigned RUN_LIMIT_CYCLES = 400000;

    // framing state of the request and the queue of frames still owed by the block
    class page_frame_checker;
        // register copies
        logic [START_W-1:0] start_cfg;
        logic [LEN_W-1:0]   length_cfg;

        // request state
        logic [CRC_W-1:0]   crc_acc;
        logic [12:0]        page_pos;
        logic [LEN_W-1:0]   left;
        logic [ADDR_W-1:0]  wr_ptr;
        logic [ADDR_W-1:0]  slot_ptr;
        logic               done;

        result_t            owed_frames[$];
        int unsigned        frames_seen;
        int unsigned        errors;

        function new();
            start_cfg   = START_RESET;
            length_cfg  = LENGTH_RESET;
            frames_seen = 0;
            errors      = 0;
            restart_request();
        endfunction

        function logic [LEN_W-1:0] full_length();
            if (length_cfg > LEN_W'(MAX_REQ))
            begin
                return LEN_W'(MAX_REQ);
            end
            return length_cfg;
        endfunction

        function void restart_request();
            crc_acc  = '1;
            page_pos = 13'(start_cfg % PAGE);
            left     = full_length();
            wr_ptr   = ADDR_W'(4);
            slot_ptr = '0;
            done     = (left == '0);
        endfunction

        // reflected castagnoli register, one input bit at a time
        function logic [CRC_W-1:0] crc32c_update(logic [CRC_W-1:0] acc, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] r;
            logic             fb;
            r = acc;
            for (int k = 0; k < BYTE_W; k++)
            begin
                fb = r[0] ^ b[k];
                r  = {1'b0, r[CRC_W-1:1]} ^ (fb ? 32'h82F6_3B78 : 32'h0);
            end
            return r;
        endfunction

        function result_t encode_byte(logic [BYTE_W-1:0] b, logic eod);
            result_t r;
            logic    closes;
            r = '0;
            // after completion the byte is swallowed and the totals come back
            if (done)
            begin
                r.request_done   = 1'b1;
                r.encoded_size   = slot_ptr;
                r.bytes_consumed = full_length() - left;
                return r;
            end
            r.wire_address = wr_ptr;
            r.byte_out     = b;
            crc_acc  = crc32c_update(crc_acc, b);
            wr_ptr   = wr_ptr + 1'b1;
            page_pos = page_pos + 1'b1;
            left     = left - 1'b1;
            closes   = eod || (left == '0) || (page_pos >= 13'(PAGE));
            r.encoded_size = wr_ptr;
            if (closes)
            begin
                r.crc_valid   = 1'b1;
                r.crc_value   = ~crc_acc;
                r.crc_address = slot_ptr;
                slot_ptr = wr_ptr;
                wr_ptr   = wr_ptr + ADDR_W'(4);
                crc_acc  = '1;
                page_pos = '0;
                if (eod || left == '0)
                begin
                    done = 1'b1;
                end
            end
            r.request_done   = done;
            r.bytes_consumed = full_length() - left;
            return r;
        endfunction

        function void accept_byte(logic [BYTE_W-1:0] b, logic eod);
            owed_frames.push_back(encode_byte(b, eod));
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            if (idx == REG_START_IN_PAGE)
            begin
                start_cfg = val[START_W-1:0];
            end
            else if (idx == REG_REQUEST_LENGTH)
            begin
                length_cfg = val;
            end
            restart_request();
        endfunction

        function int unsigned pending();
            return owed_frames.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(string field, logic [CRC_W-1:0] got, logic [CRC_W-1:0] want);
            if (got !== want)
            begin
                report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                          frames_seen, field, got, want));
            end
        endtask

        task check_frame(result_t got);
            result_t want;
            if (owed_frames.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                          frames_seen));
                frames_seen++;
                return;
            end
            want = owed_frames.pop_front();
            check_field("wire_address", 32'(got.wire_address), 32'(want.wire_address));
            check_field("byte_out",     32'(got.byte_out),     32'(want.byte_out));
            check_field("crc_valid",    32'(got.crc_valid),    32'(want.crc_valid));
            check_field("crc_value",    got.crc_value,         want.crc_value);
            check_field("crc_address",  32'(got.crc_address),  32'(want.crc_address));
            check_field("request_done", 32'(got.request_done), 32'(want.request_done));
            check_field("encoded_size", 32'(got.encoded_size), 32'(want.encoded_size));
            check_field("bytes_consumed", 32'(got.bytes_consumed), 32'(want.bytes_consumed));
            frames_seen++;
        endtask

        task flush_owed();
            while (owed_frames.size() != 0)
            begin
                void'(owed_frames.pop_front());
                report_mismatch("result never arrived");
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    pcrc_data_if   data_ch ();
    pcrc_result_if res_ch ();
    pcrc_cfg_if    cfg_ch ();

    page_crc32c_interleave_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    page_frame_checker framer = new();

    // idling odds out of a hundred, and the receiver hold-off left in cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(8 * RUN_LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one byte, idling beforehand at the current odds; returns once the item is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        data_ch.valid       <= 1'b1;
        data_ch.data_byte   <= b;
        data_ch.end_of_data <= eod;
        @(posedge clk);
        while (!data_ch.ready)
        begin
            @(posedge clk);
        end
        framer.accept_byte(b, eod);
    endtask

    // registers only change with nothing in flight; the block answers in the cycle
    // after each item, and the extra wait before the writes covers it
    task automatic configure(input logic set_start, input logic [LEN_W-1:0] start_val,
                             input logic set_length, input logic [LEN_W-1:0] length_val);
        data_ch.valid <= 1'b0;
        @(posedge clk);
        while (framer.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        if (set_start)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_START_IN_PAGE;
            cfg_ch.data  <= start_val;
            @(posedge clk);
            while (!cfg_ch.ready)
            begin
                @(posedge clk);
            end
            framer.write_register(REG_START_IN_PAGE, start_val);
        end
        if (set_length)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_REQUEST_LENGTH;
            cfg_ch.data  <= length_val;
            @(posedge clk);
            while (!cfg_ch.ready)
            begin
                @(posedge clk);
            end
            framer.write_register(REG_REQUEST_LENGTH, length_val);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: check each accepted item, then pick ready for the next cycle
    initial
    begin
        result_t got;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.wire_address   = res_ch.wire_address;
                got.byte_out       = res_ch.byte_out;
                got.crc_valid      = res_ch.crc_valid;
                got.crc_value      = res_ch.crc_value;
                got.crc_address    = res_ch.crc_address;
                got.request_done   = res_ch.request_done;
                got.encoded_size   = res_ch.encoded_size;
                got.bytes_consumed = res_ch.bytes_consumed;
                framer.check_frame(got);
            end
            // long hold-off lets the block fill up and push back on its input
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned      useful;
        int unsigned      phase;
        int unsigned      cap;
        int unsigned      sent;
        int unsigned      eod_odds;
        int unsigned      waited;
        logic [LEN_W-1:0] start_val;
        logic [LEN_W-1:0] length_val;
        logic             set_start;
        logic             set_length;

        rst_n               <= 1'b0;
        data_ch.valid       <= 1'b0;
        data_ch.data_byte   <= '0;
        data_ch.end_of_data <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_START_IN_PAGE;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // out of reset the request is one byte from the start of a page
        send_byte(8'hFF, 1'b0);
        // request already complete: the item is swallowed
        send_byte(8'h00, 1'b0);

        // two bytes short of a page end, so the first fragment is short
        configure(1'b1, LEN_W'(4094), 1'b1, LEN_W'(5));
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);

        // zero length finishes at once with nothing encoded
        configure(1'b1, '0, 1'b1, '0);
        send_byte(8'h7F, 1'b1);

        // widest length saturates; the file ends mid-page, then one more item
        configure(1'b1, LEN_W'(100), 1'b1, '1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h99, 1'b0);

        // last byte of a page: one-byte first fragment
        configure(1'b1, LEN_W'(4095), 1'b1, LEN_W'(3));
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b0);

        // receiver holds off while the sender keeps offering items
        configure(1'b1, LEN_W'(10), 1'b1, LEN_W'(MAX_REQ));
        hold_left = 300;
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'($urandom), 1'b0);
        end

        // random requests, rotating through the idling patterns
        useful = 0;
        phase  = 0;
        while (useful < RANDOM_BYTES)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase

            if (phase == 5)
            begin
                // request ends exactly on a page boundary
                length_val = LEN_W'($urandom_range(1, 300));
                start_val  = LEN_W'(PAGE) - length_val;
                set_start  = 1'b1;
                set_length = 1'b1;
                cap        = 32'(length_val);
                eod_odds   = 0;
            end
            else
            begin
                case ($urandom_range(5))
                    0:       start_val = '0;
                    1:       start_val = LEN_W'(PAGE - 1);
                    2, 3:    start_val = LEN_W'($urandom_range(PAGE - 1, PAGE - 200));
                    default: start_val = LEN_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0:       length_val = '0;
                    1:       length_val = '1;
                    2:       length_val = LEN_W'(MAX_REQ);
                    3:       length_val = LEN_W'($urandom);
                    default: length_val = LEN_W'($urandom_range(1, 400));
                endcase
                // now and then only one register changes
                set_start  = ($urandom_range(5) != 0);
                set_length = !set_start || ($urandom_range(5) != 0);
                cap        = $urandom_range(20, 500);
                // some requests are cut short by the file ending often
                eod_odds   = ($urandom_range(4) == 0) ? 15 : 200;
            end

            configure(set_start, start_val, set_length, length_val);

            sent = 0;
            while (!framer.done && sent < cap)
            begin
                send_byte(8'($urandom),
                          (eod_odds != 0) && ($urandom_range(eod_odds - 1) == 0));
                sent++;
                useful++;
            end
            // a few items after completion
            if (framer.done)
            begin
                repeat ($urandom_range(2)) send_byte(8'($urandom), 1'($urandom));
            end
            phase++;
        end

        data_ch.valid <= 1'b0;
        waited = 0;
        while (framer.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        framer.flush_owed();

        if (framer.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
